FILE: rtl/tbcs_pkg.sv
// ============================================================================
// tbcs_pkg: shared types and constants
// Op codes, command codes, status bits, version text and queue entry type.
// ============================================================================
`default_nettype none
package tbcs_pkg;
    localparam logic [2:0] OP_ADDR  = 3'd0;
    localparam logic [2:0] OP_RX    = 3'd1;
    localparam logic [2:0] OP_REQ   = 3'd2;
    localparam logic [2:0] OP_STOP  = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd5;

    localparam logic [7:0] CMD_NEW        = 8'hFF;
    localparam logic [7:0] CMD_VERSION    = 8'h01;
    localparam logic [7:0] CMD_STATUS     = 8'h02;
    localparam logic [7:0] CMD_PAGESIZE   = 8'h03;
    localparam logic [7:0] CMD_FLASHSTART = 8'h05;
    localparam logic [7:0] CMD_FLASHIT    = 8'h06;
    localparam logic [7:0] CMD_REBOOT     = 8'h10;

    localparam logic [7:0] ST_WAITING  = 8'h01;
    localparam logic [7:0] ST_READY    = 8'h02;
    localparam logic [7:0] ST_FLASHING = 8'h04;

    localparam logic [1:0] MODE_WAIT  = 2'd0;
    localparam logic [1:0] MODE_FLASH = 2'd1;
    localparam logic [1:0] MODE_BOOT  = 2'd2;

    localparam logic [1:0] REPLY_ACK  = 2'd0;
    localparam logic [1:0] REPLY_STOP = 2'd1;
    localparam logic [1:0] REPLY_NONE = 2'd2;

    localparam int VER_LEN = 12;

    function automatic logic [7:0] version_byte(input logic [3:0] idx);
        logic [7:0] b;
        begin
            unique case (idx)
                4'd0:    b = 8'h74;
                4'd1:    b = 8'h70;
                4'd2:    b = 8'h62;
                4'd3:    b = 8'h6F;
                4'd4:    b = 8'h6F;
                4'd5:    b = 8'h74;
                4'd6:    b = 8'h20;
                4'd7:    b = 8'h76;
                4'd8:    b = 8'h30;
                4'd9:    b = 8'h2E;
                4'd10:   b = 8'h31;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    // Classified item handed from front to back
    typedef struct packed {
        logic        flush;   // page done: emit words
        logic        boot;    // boot flag after this item
        logic [13:0] base;    // page byte address for the words
        logic [1:0]  reply;
        logic [7:0]  tx;
    } job_t;
endpackage
`default_nettype wire

FILE: rtl/tbcs_if.sv
// ============================================================================
// tbcs_in_if / tbcs_out_if / tbcs_cfg_if: valid-ready channels
// Channel interfaces with source and sink modports.
// ============================================================================
`default_nettype none
interface tbcs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] rx_byte;
    modport source (output valid, op, rx_byte, input ready);
    modport sink (input valid, op, rx_byte, output ready);
endinterface

interface tbcs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  bus_reply;
    logic [7:0]  tx_byte;
    logic        flash_write;
    logic [13:0] flash_address;
    logic [15:0] flash_word;
    logic        last;
    logic        boot_app;
    modport source (output valid, bus_reply, tx_byte, flash_write, flash_address,
                    flash_word, last, boot_app, input ready);
    modport sink (input valid, bus_reply, tx_byte, flash_write, flash_address,
                  flash_word, last, boot_app, output ready);
endinterface

interface tbcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/tbcs_ram.sv
// ============================================================================
// tbcs_ram: generic single-port-write RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none
module tbcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/tbcs_front.sv
// ============================================================================
// tbcs_front: command decoder
// Accepts bus events, runs commands, stores page bytes, pushes one job each.
// ============================================================================
`default_nettype none
module tbcs_front #(
    parameter int PAGE_BYTES     = 64,
    parameter int RESPONSE_DEPTH = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    tbcs_in_if.sink                            in_ch,
    tbcs_cfg_if.sink                           cfg_ch,
    input  wire logic                          q_full,
    input  wire logic                          busy,
    output logic                               q_push,
    output tbcs_pkg::job_t                     q_job,
    output logic                               pg_we,
    output logic [$clog2(PAGE_BYTES)-1:0]      pg_waddr,
    output logic [7:0]                         pg_wdata,
    output logic                               boot_app
);
    localparam int RW = $clog2(RESPONSE_DEPTH + 1);
    localparam int FW = $clog2(PAGE_BYTES + 1);
    localparam int RN = (tbcs_pkg::VER_LEN < RESPONSE_DEPTH) ?
                        tbcs_pkg::VER_LEN : RESPONSE_DEPTH;
    localparam int RI = (RESPONSE_DEPTH > 1) ? $clog2(RESPONSE_DEPTH) : 1;

    logic [1:0]  mode_reg;
    logic [15:0] tcount_reg;
    logic [7:0]  status_reg;
    logic [7:0]  cmd_reg;
    logic [7:0]  resp_reg [RESPONSE_DEPTH];
    logic [RW-1:0] rsize_reg;
    logic [RW-1:0] rpos_reg;
    logic [15:0] paddr_reg;
    logic [FW-1:0] fill_reg;

    logic        acc;
    logic [7:0]  d;
    logic [7:0]  cmd_eff;
    logic        flashing;

    // Stall while the queue is full, the back end is draining a page or a write is offered
    assign in_ch.ready  = !q_full && !busy && !cfg_ch.valid;
    assign cfg_ch.ready = 1'b1;
    assign acc = in_ch.valid && in_ch.ready;
    assign d   = in_ch.rx_byte;
    assign cmd_eff = (cmd_reg == tbcs_pkg::CMD_NEW) ? d : cmd_reg;
    assign flashing = (status_reg & tbcs_pkg::ST_FLASHING) != 8'h00;
    assign boot_app  = (mode_reg == tbcs_pkg::MODE_BOOT);

    // Page byte write
    always_comb
    begin
        pg_we    = acc && in_ch.op == tbcs_pkg::OP_RX && flashing
                   && paddr_reg != 16'hFFFF && fill_reg < FW'(PAGE_BYTES);
        pg_waddr = fill_reg[$clog2(PAGE_BYTES)-1:0];
        pg_wdata = d;
    end

    // Classify item into a job
    always_comb
    begin
        q_push    = acc;
        q_job.flush = pg_we && fill_reg == FW'(PAGE_BYTES - 1);
        q_job.base  = paddr_reg[13:0];
        q_job.boot  = (mode_reg == tbcs_pkg::MODE_BOOT)
                      || (in_ch.op == tbcs_pkg::OP_TICK && tcount_reg == 16'd1
                          && mode_reg == tbcs_pkg::MODE_WAIT)
                      || (in_ch.op == tbcs_pkg::OP_RX && !flashing
                          && cmd_eff == tbcs_pkg::CMD_REBOOT);
        q_job.reply = tbcs_pkg::REPLY_ACK;
        q_job.tx    = 8'hFF;
        unique case (in_ch.op)
            tbcs_pkg::OP_ADDR, tbcs_pkg::OP_RX, tbcs_pkg::OP_STOP:
                q_job.reply = tbcs_pkg::REPLY_ACK;
            tbcs_pkg::OP_REQ:
            begin
                if (rpos_reg < rsize_reg && rpos_reg < RW'(RESPONSE_DEPTH))
                begin
                    q_job.tx = resp_reg[rpos_reg[RI-1:0]];
                end
            end
            tbcs_pkg::OP_TICK:
                q_job.reply = tbcs_pkg::REPLY_NONE;
            default:
                q_job.reply = tbcs_pkg::REPLY_STOP;
        endcase
    end

    // Command state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= tbcs_pkg::MODE_WAIT;
            tcount_reg <= 16'd8;
            status_reg <= tbcs_pkg::ST_WAITING;
            cmd_reg    <= tbcs_pkg::CMD_NEW;
            rsize_reg  <= '0;
            rpos_reg   <= '0;
            paddr_reg  <= 16'hFFFF;
            fill_reg   <= '0;
        end
        else if (cfg_ch.valid)
        begin
            tcount_reg <= cfg_ch.data;
        end
        else if (acc)
        begin
            if (in_ch.op == tbcs_pkg::OP_REQ)
            begin
                if (rpos_reg < rsize_reg && rpos_reg < RW'(RESPONSE_DEPTH))
                begin
                    rpos_reg <= rpos_reg + RW'(1);
                end
            end
            else if (in_ch.op == tbcs_pkg::OP_TICK)
            begin
                tcount_reg <= tcount_reg - 16'd1;
                if (tcount_reg == 16'd1 && mode_reg == tbcs_pkg::MODE_WAIT)
                begin
                    mode_reg <= tbcs_pkg::MODE_BOOT;
                end
            end
            else if (in_ch.op == tbcs_pkg::OP_RX)
            begin
                if (flashing)
                begin
                    if (paddr_reg == 16'hFFFF)
                    begin
                        paddr_reg <= {2'b00, d, 6'b000000};
                    end
                    else if (pg_we)
                    begin
                        if (q_job.flush)
                        begin
                            paddr_reg  <= 16'hFFFF;
                            fill_reg   <= '0;
                            status_reg <= status_reg & ~tbcs_pkg::ST_FLASHING;
                            cmd_reg    <= tbcs_pkg::CMD_NEW;
                        end
                        else
                        begin
                            fill_reg <= fill_reg + FW'(1);
                        end
                    end
                end
                else
                begin
                    cmd_reg <= cmd_eff;
                    unique case (cmd_eff)
                        tbcs_pkg::CMD_VERSION:
                        begin
                            rsize_reg <= RW'(RN);
                            rpos_reg  <= '0;
                            cmd_reg   <= tbcs_pkg::CMD_NEW;
                        end
                        tbcs_pkg::CMD_STATUS, tbcs_pkg::CMD_PAGESIZE:
                        begin
                            rsize_reg <= RW'(1);
                            rpos_reg  <= '0;
                            cmd_reg   <= tbcs_pkg::CMD_NEW;
                        end
                        tbcs_pkg::CMD_FLASHIT:
                        begin
                            status_reg <= status_reg | tbcs_pkg::ST_FLASHING;
                            paddr_reg  <= 16'hFFFF;
                            fill_reg   <= '0;
                        end
                        tbcs_pkg::CMD_FLASHSTART:
                        begin
                            if (mode_reg != tbcs_pkg::MODE_BOOT)
                            begin
                                mode_reg <= tbcs_pkg::MODE_FLASH;
                            end
                            status_reg <= tbcs_pkg::ST_READY;
                            cmd_reg    <= tbcs_pkg::CMD_NEW;
                        end
                        tbcs_pkg::CMD_REBOOT:
                            mode_reg <= tbcs_pkg::MODE_BOOT;
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    // Response buffer payload
    always_ff @(posedge clk)
    begin
        if (acc && in_ch.op == tbcs_pkg::OP_RX && !flashing)
        begin
            if (cmd_eff == tbcs_pkg::CMD_VERSION)
            begin
                for (int i = 0; i < RN; i++)
                begin
                    resp_reg[i] <= tbcs_pkg::version_byte(4'(i));
                end
            end
            else if (cmd_eff == tbcs_pkg::CMD_STATUS)
            begin
                resp_reg[0] <= status_reg;
            end
            else if (cmd_eff == tbcs_pkg::CMD_PAGESIZE)
            begin
                resp_reg[0] <= 8'(PAGE_BYTES);
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/tbcs_back.sv
// ============================================================================
// tbcs_back: result generator
// Pops jobs, emits single results or drains a page as word writes.
// ============================================================================
`default_nettype none
module tbcs_back #(
    parameter int PAGE_BYTES = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_empty,
    input  tbcs_pkg::job_t                q_job,
    output logic                          q_pop,
    output logic                          busy,
    output logic [$clog2(PAGE_BYTES)-1:0] pg_raddr,
    input  wire logic [7:0]               pg_rdata,
    tbcs_out_if.source                    out_ch
);
    localparam int AW = $clog2(PAGE_BYTES);
    localparam int NW = (PAGE_BYTES + 1) / 2;
    localparam int BW = $clog2(PAGE_BYTES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LO   = 2'd1;
    localparam logic [1:0] S_HI   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]    state_reg;
    logic [BW-1:0] off_reg;
    logic [7:0]    lo_reg;
    logic [13:0]   base_reg;
    logic          ov_reg;
    logic          hi_ok;

    assign busy = (state_reg != S_IDLE) || (!q_empty && q_job.flush);
    assign out_ch.valid = ov_reg;
    assign hi_ok = (off_reg + BW'(1)) < BW'(PAGE_BYTES);

    // Read the low byte first, then hold the high byte address until the word leaves
    always_comb
    begin
        q_pop = 1'b0;
        pg_raddr = off_reg[AW-1:0];
        if ((state_reg == S_HI || state_reg == S_OUT) && hi_ok)
        begin
            pg_raddr = AW'(off_reg + BW'(1));
        end
        if (state_reg == S_IDLE && !q_empty && (!ov_reg || out_ch.ready))
        begin
            q_pop = 1'b1;
        end
    end

    // Result sequencer: reads two page bytes per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            off_reg   <= '0;
        end
        else
        begin
            if (ov_reg && out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        out_ch.boot_app <= q_job.boot;
                        if (q_job.flush)
                        begin
                            state_reg <= S_LO;
                            off_reg   <= '0;
                            base_reg  <= q_job.base;
                        end
                        else
                        begin
                            ov_reg               <= 1'b1;
                            out_ch.bus_reply     <= q_job.reply;
                            out_ch.tx_byte       <= q_job.tx;
                            out_ch.flash_write   <= 1'b0;
                            out_ch.flash_address <= '0;
                            out_ch.flash_word    <= '0;
                            out_ch.last          <= 1'b1;
                        end
                    end
                end
                S_LO:
                    state_reg <= S_HI;
                S_HI:
                begin
                    lo_reg    <= pg_rdata;
                    state_reg <= S_OUT;
                end
                default:
                begin
                    if (!ov_reg || out_ch.ready)
                    begin
                        ov_reg             <= 1'b1;
                        out_ch.tx_byte     <= 8'hFF;
                        out_ch.flash_write <= 1'b1;
                        out_ch.flash_address <= base_reg + 14'(off_reg);
                        out_ch.flash_word  <= {hi_ok ? pg_rdata : 8'h00, lo_reg};
                        if (off_reg >= BW'(2 * NW - 2))
                        begin
                            out_ch.bus_reply <= tbcs_pkg::REPLY_ACK;
                            out_ch.last      <= 1'b1;
                            state_reg        <= S_IDLE;
                        end
                        else
                        begin
                            out_ch.bus_reply <= tbcs_pkg::REPLY_NONE;
                            out_ch.last      <= 1'b0;
                            off_reg          <= off_reg + BW'(2);
                            state_reg        <= S_LO;
                        end
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/tbcs_queue.sv
// ============================================================================
// tbcs_queue: two-entry job queue
// Decouples the decoder from the result generator.
// ============================================================================
`default_nettype none
module tbcs_queue (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  tbcs_pkg::job_t din,
    input  wire logic     pop,
    output tbcs_pkg::job_t dout,
    output logic          full,
    output logic          empty
);
    tbcs_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign dout  = mem_reg[rp_reg];

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= din;
    end
endmodule
`default_nettype wire

FILE: rtl/twi_bootloader_command_slave.sv
// ============================================================================
// twi_bootloader_command_slave: bootloader command side on a two-wire bus
// Decoder front end, job queue and result generator with a page RAM.
// ============================================================================
// Items pass the job queue, then the output register; one item per cycle while
// the output is ready. A completed page drains as (PAGE_BYTES+1)/2 words via
// S_LO, S_HI and S_OUT, with two registered page RAM reads; input stalls meanwhile.
// Reset (rst_n low, asynchronous): wait mode, timeout 8, no command pending.
`default_nettype none
module twi_bootloader_command_slave #(
    parameter int PAGE_BYTES     = 64,
    parameter int RESPONSE_DEPTH = 12
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tbcs_in_if.sink    in_ch,
    tbcs_cfg_if.sink   cfg_ch,
    tbcs_out_if.source out_ch
);
    localparam int AW = $clog2(PAGE_BYTES);

    logic           q_push, q_pop, q_full, q_empty, busy, pg_we, boot_app;
    tbcs_pkg::job_t f_job, b_job;
    logic [AW-1:0]  pg_waddr, pg_raddr;
    logic [7:0]     pg_wdata, pg_rdata;

    tbcs_front #(.PAGE_BYTES(PAGE_BYTES), .RESPONSE_DEPTH(RESPONSE_DEPTH)) u_front (
        .clk, .rst_n, .in_ch, .cfg_ch, .q_full, .busy, .q_push, .q_job(f_job),
        .pg_we, .pg_waddr, .pg_wdata, .boot_app
    );

    tbcs_queue u_queue (
        .clk, .rst_n, .push(q_push), .din(f_job), .pop(q_pop), .dout(b_job),
        .full(q_full), .empty(q_empty)
    );

    tbcs_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page (
        .clk, .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
        .raddr(pg_raddr), .rdata(pg_rdata)
    );

    tbcs_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
        .clk, .rst_n, .q_empty, .q_job(b_job), .q_pop, .busy, .pg_raddr,
        .pg_rdata, .out_ch
    );

    // Queue never overflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push) else $error("job queue overflow");

    // Write results always carry a write flag and no tx data
    a_write_tx: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.flash_write |-> out_ch.tx_byte == 8'hFF)
        else $error("write result with tx data");

    // Boot request is sticky
    a_boot_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(boot_app) |-> boot_app) else $error("boot flag dropped");
endmodule
`default_nettype wire
